/* design/ple_pkg.sv */
package ple_pkg;

   // store size and derived widths
   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int ACT_W    = 3;
   localparam int POS_W    = 7;
   localparam int FOUND_W  = 7;
   localparam int ECNT_W   = 7;
   localparam int STS_W    = 2;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int WIDE_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

   // two-level match encoder: groups of eight cells
   localparam int GRP_N     = 8;
   localparam int SUB_W     = 3;
   localparam int NGROUP    = (CAPACITY + GRP_N - 1) / GRP_N;
   localparam int GRP_W     = (NGROUP > 1) ? $clog2(NGROUP) : 1;
   localparam int LOC_W     = GRP_W + SUB_W;
   localparam int LOC_EXT_W = (LOC_W > FOUND_W) ? LOC_W : FOUND_W;

   // stream payload widths
   localparam int REQ_BITS = ACT_W + POS_W + DATA_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = FOUND_W + ECNT_W + STS_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [FOUND_W-1:0] FOUND_NONE = {FOUND_W{1'b1}};

   typedef enum logic [ACT_W-1:0] {
      ACT_ADD_FRONT = 3'd0,
      ACT_ADD_BACK  = 3'd1,
      ACT_ADD_AT    = 3'd2,
      ACT_REM_FRONT = 3'd3,
      ACT_REM_BACK  = 3'd4,
      ACT_REM_AT    = 3'd5,
      ACT_CLEAR     = 3'd6,
      ACT_FIND      = 3'd7
   } action_type;

   typedef enum logic [STS_W-1:0] {
      STS_DONE = 2'd0,
      STS_BAD  = 2'd1,
      STS_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_PICK = 2'd2
   } state_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic              ins;
      logic              rem;
      logic [CNT_W-1:0]  pos;
      logic [CNT_W-1:0]  count;
      logic [DATA_W-1:0] value;
   } cell_ctl_type;

   typedef struct packed {
      status_type         status;
      logic [ECNT_W-1:0]  count;
      logic [FOUND_W-1:0] found;
   } result_type;

endpackage

/* design/ple_cell.sv */
module ple_cell (
   input  logic                      clock,
   input  logic [ple_pkg::CNT_W-1:0] idx,
   input  ple_pkg::cell_ctl_type     ctl,
   input  logic [ple_pkg::DATA_W-1:0] left_value,
   input  logic [ple_pkg::DATA_W-1:0] right_value,
   output logic [ple_pkg::DATA_W-1:0] entry_value,
   output logic                      match
);
   import ple_pkg::*;

   logic [DATA_W-1:0] entry_ff, entry_in;
   logic              match_ff, match_in;

   // shift up on insert, down on remove, load at the insert point
   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins) begin
         if (idx > ctl.pos) begin
            entry_in = left_value;
         end else if (idx == ctl.pos) begin
            entry_in = ctl.value;
         end
      end else if (ctl.rem) begin
         if (idx >= ctl.pos) begin
            entry_in = right_value;
         end
      end
   end

   // key compare, only live entries count
   assign match_in = (entry_ff == ctl.value) && (idx < ctl.count);

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry_value = entry_ff;
   assign match       = match_ff;

endmodule

/* design/ple_find.sv */
module ple_find (
   input  logic                        clock,
   input  logic [ple_pkg::CAPACITY-1:0] match,
   output logic                        hit,
   output logic [ple_pkg::LOC_W-1:0]   loc
);
   import ple_pkg::*;

   logic [NGROUP*GRP_N-1:0] match_pad;
   logic [NGROUP-1:0]       grp_any_ff, grp_any_in;
   logic [SUB_W-1:0]        grp_first_ff [NGROUP];
   logic [SUB_W-1:0]        grp_first_in [NGROUP];

   assign match_pad = (NGROUP*GRP_N)'(match);

   // first stage: lowest match inside each group of eight
   always_comb begin
      for (int g = 0; g < NGROUP; g++) begin
         grp_any_in[g]   = |match_pad[g*GRP_N +: GRP_N];
         grp_first_in[g] = '0;
         for (int b = GRP_N - 1; b >= 0; b--) begin
            if (match_pad[g*GRP_N + b]) begin
               grp_first_in[g] = SUB_W'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_any_ff <= grp_any_in;
      for (int g = 0; g < NGROUP; g++) begin
         grp_first_ff[g] <= grp_first_in[g];
      end
   end

   // second stage: lowest group that holds a match
   always_comb begin
      logic [GRP_W-1:0] sel;
      sel = '0;
      for (int g = NGROUP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            sel = GRP_W'(g);
         end
      end
      hit = |grp_any_ff;
      loc = {sel, grp_first_ff[sel]};
   end

endmodule

/* design/positional_list_engine.sv */
// channel  dir  ports             payload
// req      in   req_tvalid/tready action, position, item_value
// rsp      out  rsp_tvalid/tready found_position, entry_count, status
//
// insert and remove shift the whole cell chain at the accept edge; clear only
// zeroes the entry count. find passes cell compare, group encode, group pick.
// reset clears the entry count and the control state; stored values stay
// undefined until written. a result register plus one holding slot let the
// next item enter while a result waits on a stalled rsp side.
module positional_list_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // action[2:0], position[9:3], item_value[41:10], zero fill
   input  logic [ple_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // found_position[6:0], entry_count[13:7], status[15:14]
   output logic [ple_pkg::RSP_W-1:0]  rsp_tdata
);
   import ple_pkg::*;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               hold_valid_ff, hold_valid_in;
   result_type         hold_ff, hold_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   action_type         req_action;
   logic [POS_W-1:0]   req_position;
   logic [DATA_W-1:0]  req_value;
   logic               req_accept;
   logic               out_move;
   logic               edit_result;
   logic               find_result;
   logic               is_insert;
   cell_ctl_type       ctl;
   result_type         edit_res;
   result_type         find_res;

   logic [DATA_W-1:0]  entry_value [CAPACITY];
   logic [CAPACITY-1:0] match;
   logic               find_hit;
   logic [LOC_W-1:0]   find_loc;
   logic [LOC_EXT_W-1:0] find_loc_ext;

   // request fields
   assign req_action   = action_type'(req_tdata[ACT_W-1:0]);
   assign req_position = req_tdata[ACT_W +: POS_W];
   assign req_value    = req_tdata[ACT_W+POS_W +: DATA_W];

   assign out_move   = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_action == ACT_FIND)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: state_in = ST_PICK;
         ST_PICK: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready  = 1'b0;
      find_result = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready  = !hold_valid_ff || out_move;
         ST_SCAN: req_tready  = 1'b0;
         ST_PICK: find_result = 1'b1;
         default: req_tready  = 1'b0;
      endcase
   end

   // request decode: bounds checks, chain control, new count
   always_comb begin
      logic [WIDE_W-1:0] count_w;
      logic [WIDE_W-1:0] ins_pos;
      logic [WIDE_W-1:0] rem_pos;
      logic [WIDE_W-1:0] after_w;
      logic              ins_ok;
      logic              rem_ok;
      status_type        sts;
      count_w   = WIDE_W'(count_ff);
      ins_pos   = '0;
      rem_pos   = '0;
      is_insert = 1'b0;
      ins_ok    = 1'b0;
      rem_ok    = 1'b0;
      sts       = STS_DONE;
      count_in  = count_ff;
      unique case (req_action) inside
         ACT_ADD_FRONT, ACT_ADD_BACK, ACT_ADD_AT: begin
            is_insert = 1'b1;
            if (req_action == ACT_ADD_BACK) begin
               ins_pos = count_w;
            end else if (req_action == ACT_ADD_AT) begin
               ins_pos = WIDE_W'(req_position);
            end
            if (ins_pos > count_w) begin
               sts = STS_BAD;
            end else if (count_w == WIDE_W'(CAPACITY)) begin
               sts = STS_FULL;
            end else begin
               ins_ok = 1'b1;
            end
         end
         ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_AT: begin
            if (req_action == ACT_REM_BACK) begin
               rem_pos = count_w - WIDE_W'(1);
            end else if (req_action == ACT_REM_AT) begin
               rem_pos = WIDE_W'(req_position);
            end
            if ((count_ff == '0) || (rem_pos >= count_w)) begin
               sts = STS_BAD;
            end else begin
               rem_ok = 1'b1;
            end
         end
         ACT_CLEAR, ACT_FIND: sts = STS_DONE;
         default: sts = STS_DONE;
      endcase

      if (req_accept) begin
         if (ins_ok) begin
            count_in = count_ff + CNT_W'(1);
         end else if (rem_ok) begin
            count_in = count_ff - CNT_W'(1);
         end else if (req_action == ACT_CLEAR) begin
            count_in = '0;
         end
      end

      ctl.ins   = req_accept && ins_ok;
      ctl.rem   = req_accept && rem_ok;
      ctl.pos   = ins_ok ? ins_pos[CNT_W-1:0] : rem_pos[CNT_W-1:0];
      ctl.count = count_ff;
      ctl.value = req_value;

      after_w         = WIDE_W'(count_in);
      edit_res.found  = FOUND_NONE;
      edit_res.count  = after_w[ECNT_W-1:0];
      edit_res.status = sts;
   end

   assign edit_result = req_accept && (req_action != ACT_FIND);

   // chain of cells, each handing its value to both neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_v;
      logic [DATA_W-1:0] right_v;
      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_left
         assign left_v = entry_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_right
         assign right_v = entry_value[i+1];
      end
      ple_cell u_cell (
         .clock       (clock),
         .idx         (CNT_W'(i)),
         .ctl         (ctl),
         .left_value  (left_v),
         .right_value (right_v),
         .entry_value (entry_value[i]),
         .match       (match[i])
      );
   end

   ple_find u_find (
      .clock (clock),
      .match (match),
      .hit   (find_hit),
      .loc   (find_loc)
   );

   // find result, low bits of the matching index
   always_comb begin
      logic [WIDE_W-1:0] cnt_w;
      cnt_w           = WIDE_W'(count_ff);
      find_loc_ext    = LOC_EXT_W'(find_loc);
      find_res.found  = find_hit ? find_loc_ext[FOUND_W-1:0] : FOUND_NONE;
      find_res.count  = cnt_w[ECNT_W-1:0];
      find_res.status = STS_DONE;
   end

   // holding slot and output register
   always_comb begin
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff && !out_move;
      if (edit_result) begin
         hold_in       = edit_res;
         hold_valid_in = 1'b1;
      end else if (find_result) begin
         hold_in       = find_res;
         hold_valid_in = 1'b1;
      end
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_move) begin
         rsp_in       = hold_ff;
         rsp_valid_in = hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_ff.status, rsp_ff.count, rsp_ff.found});

   // count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // a completed insert grows the list by exactly one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_insert && (edit_res.status == STS_DONE))
      |=> (count_ff == CNT_W'($past(count_ff) + CNT_W'(1))))
      else $error("insert did not grow the count by one");

   // a find walks compare, encode and pick, then yields its result
   a_find_walk: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_action == ACT_FIND))
      |=> (state_ff == ST_SCAN) ##1 (state_ff == ST_PICK) ##1 hold_valid_ff)
      else $error("find did not finish in three cycles");

   // the holding slot is never overwritten while full and stalled
   a_hold_safe: assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && !out_move) |-> !(edit_result || find_result))
      else $error("result slot overwritten");

endmodule
